FILE: hw/rtl/sfc_pkg.sv
// Shared constants, types and the byte-wide CRC update for the serial frame checker.
// Used by serial_frame_checker_crc16; depends on nothing else.
package sfc_pkg;

  // Frame geometry and checking constants.
  localparam int MAX_FRAME      = 256;
  localparam int COUNT_W        = $clog2(MAX_FRAME + 2);
  localparam int FRAME_W        = 9;
  localparam int WINDOW         = 5;
  localparam int FRAME_OVERHEAD = 2 + 2 + 2 + 3 + 2;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] FRAME_HEADER = 16'h01AA;
  localparam logic [15:0] ANY_COMMAND  = 16'h0101;

  localparam logic [7:0] FOOTER_0 = 8'hFF;
  localparam logic [7:0] FOOTER_1 = 8'h0D;
  localparam logic [7:0] FOOTER_2 = 8'h0A;

  // Verdict codes, first failing check wins.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_BAD_CMD    = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_BAD_CRC    = 3'd4
  } status_t;

  // CRC16/CCITT-FALSE update by one byte, MSB first, no reflection.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] v;
    v = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

FILE: hw/rtl/serial_frame_checker_crc16.sv
// Accepted bytes wait in the input register; a verdict goes on to the result register.
// One byte per cycle unless stalled; the frame state updates once per byte in one pass.
// A stalled verdict blocks only the byte that would produce the next verdict.
// Reset (rst, synchronous) clears the frame state, the expected command and both valids.
// Top level of the serial frame checker; depends on sfc_pkg.
module serial_frame_checker_crc16 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [15:0]                        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sfc_pkg::status_t                   status,
  output logic [15:0]                        command,
  output logic [15:0]                        length_field,
  output logic [sfc_pkg::FRAME_W-1:0]        frame_bytes
);
  import sfc_pkg::*;

  // Configuration and input register.
  logic [15:0]        match_command;
  logic               s1_valid;
  logic [7:0]         s1_byte;

  // Frame state.
  logic [COUNT_W-1:0] byte_count;
  logic [15:0]        header_word;
  logic [15:0]        command_word;
  logic [15:0]        length_word;
  logic [15:0]        running_crc;
  logic [7:0]         recent_bytes [WINDOW];

  // Combinational results of the single pass.
  logic [COUNT_W-1:0] byte_count_next;
  logic [15:0]        header_word_next;
  logic [15:0]        command_word_next;
  logic [15:0]        length_word_next;
  logic [15:0]        running_crc_next;
  logic [15:0]        rx_crc;
  logic [15:0]        count_ext;
  logic               verdict;
  logic               advance;
  status_t            status_next;

  // The configuration register is written directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      match_command <= '0;
    end else if (cfg_wr_en) begin
      match_command <= cfg_wr_data;
    end
  end

  // Per-byte update of the frame state and the verdict decision.
  always_comb begin
    header_word_next  = header_word;
    command_word_next = command_word;
    length_word_next  = length_word;
    unique case (byte_count)
      COUNT_W'(0): header_word_next  = {s1_byte, header_word[7:0]};
      COUNT_W'(1): header_word_next  = {header_word[15:8], s1_byte};
      COUNT_W'(2): command_word_next = {s1_byte, command_word[7:0]};
      COUNT_W'(3): command_word_next = {command_word[15:8], s1_byte};
      COUNT_W'(4): length_word_next  = {s1_byte, length_word[7:0]};
      COUNT_W'(5): length_word_next  = {length_word[15:8], s1_byte};
      default: ;
    endcase

    // The oldest window byte joins the CRC as it leaves the window.
    if (byte_count >= COUNT_W'(WINDOW)) begin
      running_crc_next = crc_fold(running_crc, recent_bytes[0]);
    end else begin
      running_crc_next = running_crc;
    end

    if (byte_count < COUNT_W'(MAX_FRAME + 1)) begin
      byte_count_next = byte_count + COUNT_W'(1);
    end else begin
      byte_count_next = byte_count;
    end

    verdict = (byte_count_next >= COUNT_W'(3)) && (recent_bytes[3] == FOOTER_0) &&
              (recent_bytes[4] == FOOTER_1) && (s1_byte == FOOTER_2);
    rx_crc    = {recent_bytes[1], recent_bytes[2]};
    count_ext = 16'(byte_count_next);

    priority if (header_word_next != FRAME_HEADER) begin
      status_next = ST_BAD_HEADER;
    end else if (command_word_next != match_command &&
                 command_word_next != ANY_COMMAND) begin
      status_next = ST_BAD_CMD;
    end else if (byte_count_next > COUNT_W'(MAX_FRAME) ||
                 byte_count_next < COUNT_W'(FRAME_OVERHEAD) ||
                 length_word_next != count_ext - 16'(FRAME_OVERHEAD)) begin
      status_next = ST_BAD_LENGTH;
    end else if (running_crc_next != rx_crc) begin
      status_next = ST_BAD_CRC;
    end else begin
      status_next = ST_OK;
    end
  end

  // A byte that closes a frame moves on only when the result register frees up.
  assign advance  = !verdict || !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;

  // Input register: holds one accepted byte until it is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  // Frame state register, cleared after every verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      header_word  <= '0;
      command_word <= '0;
      length_word  <= '0;
      running_crc  <= CRC_INIT;
      for (int i = 0; i < WINDOW; i++) begin
        recent_bytes[i] <= '0;
      end
    end else if (s1_valid && advance) begin
      if (verdict) begin
        byte_count   <= '0;
        header_word  <= '0;
        command_word <= '0;
        length_word  <= '0;
        running_crc  <= CRC_INIT;
        for (int i = 0; i < WINDOW; i++) begin
          recent_bytes[i] <= '0;
        end
      end else begin
        byte_count   <= byte_count_next;
        header_word  <= header_word_next;
        command_word <= command_word_next;
        length_word  <= length_word_next;
        running_crc  <= running_crc_next;
        for (int i = 0; i < WINDOW - 1; i++) begin
          recent_bytes[i] <= recent_bytes[i + 1];
        end
        recent_bytes[WINDOW - 1] <= s1_byte;
      end
    end
  end

  // Result register: holds a verdict transaction until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && advance && verdict) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance && verdict) begin
      status       <= status_next;
      command      <= command_word_next;
      length_field <= length_word_next;
      frame_bytes  <= FRAME_W'(byte_count_next);
    end
  end

  // A stall toward the sender only comes from a pending byte.
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall raised with no pending byte");

  // A frame-closing byte never overwrites a verdict that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && verdict && out_valid && out_stall) |-> in_stall)
    else $error("verdict would overwrite a stalled result");

  // After a verdict, the next frame starts from an empty count.
  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && verdict) |=> (byte_count == '0))
    else $error("frame state not cleared after verdict");

  // The byte count saturates one past the frame limit.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(MAX_FRAME + 1))
    else $error("byte count above saturation value");

  // No byte reaches the CRC until the window has filled.
  a_crc_idle_early: assert property (@(posedge clk) disable iff (rst)
    (byte_count <= COUNT_W'(WINDOW)) |-> (running_crc == CRC_INIT))
    else $error("CRC changed before the window filled");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for serial_frame_checker_crc16: table-driven frames, then random traffic.
// Depends on sfc_pkg and the serial_frame_checker_crc16 RTL only.
module tb;
  import sfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 37;
  localparam int PHASE_BYTES = 75;

  // One verdict as seen on the result port.
  typedef struct packed {
    status_t              st;
    logic [15:0]          cmd;
    logic [15:0]          len;
    logic [FRAME_W-1:0]   nbytes;
  } verdict_t;

  typedef enum {ROW_FRAME, ROW_CFG} row_kind_t;

  // One line of the directed table: a frame to send or a command register write.
  typedef struct {
    row_kind_t   kind;
    logic [15:0] hdr, cmd, len;
    int          n;
    int          keep;
    bit          bad_crc;
    bit          pinned;
    verdict_t    want;
  } plan_row_t;

  typedef struct {
    bit       pinned;
    verdict_t v;
  } row_hint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  status_t status;
  logic [15:0] command;
  logic [15:0] length_field;
  logic [FRAME_W-1:0] frame_bytes;

  serial_frame_checker_crc16 i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .command        (command),
    .length_field   (length_field),
    .frame_bytes    (frame_bytes)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Frame tracker state, mirrored from the block's behavior.
  int          f_count;
  logic [15:0] f_hdr, f_cmd, f_len, f_crc;
  logic [7:0]  f_win [WINDOW];
  logic [15:0] want_cmd;

  verdict_t  verdict_q [$];
  row_hint_t directed_q [$];
  plan_row_t plan [$];
  verdict_t  pred, exp_v;
  row_hint_t hint;

  int errors = 0;
  int cycles = 0;
  int sent_bytes = 0;
  int verdicts = 0;
  int cfg_writes = 0;
  int st_seen [5];
  bit quiet = 1'b0;
  logic [15:0] cfg_now = 16'h0000;

  // CRC16/CCITT-FALSE, one bit at a time from the MSB of the byte.
  function automatic logic [15:0] crc_add(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  function automatic void frame_clear();
    f_count = 0;
    f_hdr = '0;
    f_cmd = '0;
    f_len = '0;
    f_crc = CRC_INIT;
    for (int i = 0; i < WINDOW; i++) f_win[i] = '0;
  endfunction

  // Advance the tracker by one byte; returns 1 with the verdict when a footer closes a frame.
  function automatic bit frame_step(input logic [7:0] b, output verdict_t v);
    int pos;
    pos = f_count;
    v = '0;
    if (f_count >= WINDOW) f_crc = crc_add(f_crc, f_win[0]);
    for (int i = 0; i < WINDOW - 1; i++) f_win[i] = f_win[i + 1];
    f_win[WINDOW - 1] = b;
    case (pos)
      0: f_hdr[15:8] = b;
      1: f_hdr[7:0]  = b;
      2: f_cmd[15:8] = b;
      3: f_cmd[7:0]  = b;
      4: f_len[15:8] = b;
      5: f_len[7:0]  = b;
      default: ;
    endcase
    if (f_count <= MAX_FRAME) f_count++;
    if (f_count < 3 || f_win[2] != FOOTER_0 || f_win[3] != FOOTER_1 || f_win[4] != FOOTER_2)
      return 1'b0;

    // First failing check wins.
    if (f_hdr != FRAME_HEADER) v.st = ST_BAD_HEADER;
    else if (f_cmd != want_cmd && f_cmd != ANY_COMMAND) v.st = ST_BAD_CMD;
    else if (f_count > MAX_FRAME || f_count < FRAME_OVERHEAD ||
             int'(f_len) != f_count - FRAME_OVERHEAD) v.st = ST_BAD_LENGTH;
    else if (f_crc != {f_win[0], f_win[1]}) v.st = ST_BAD_CRC;
    else v.st = ST_OK;
    v.cmd = f_cmd;
    v.len = f_len;
    v.nbytes = FRAME_W'(f_count);
    frame_clear();
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // Sample both channels at each edge: predict on accepted bytes, check accepted verdicts.
  always @(posedge clk) begin
    if (rst) begin
      want_cmd = 16'h0000;
      frame_clear();
    end else begin
      if (cfg_wr_en) want_cmd = cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (frame_step(rx_byte, pred)) begin
          // Directed rows may carry a verdict typed into the table.
          if (directed_q.size() != 0) begin
            hint = directed_q.pop_front();
            if (hint.pinned) pred = hint.v;
          end
          verdict_q.push_back(pred);
        end
      end
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict, expected none, actual status %0d cmd %0h",
                   $time, status, command);
        end else begin
          exp_v = verdict_q.pop_front();
          verdicts++;
          st_seen[exp_v.st]++;
          check_field("status", 16'(exp_v.st), 16'(status));
          check_field("command", exp_v.cmd, command);
          check_field("length_field", exp_v.len, length_field);
          check_field("frame_bytes", 16'(exp_v.nbytes), 16'(frame_bytes));
        end
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("serial_frame_checker_crc16 regression: fail");
      $finish;
    end
  end

  // Present one byte, with random gaps ahead of it, and hold it until the transaction completes.
  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_footer();
    send_byte(FOOTER_0);
    send_byte(FOOTER_1);
    send_byte(FOOTER_2);
  endtask

  // Header, command, length (first keep bytes); payload and CRC only if keep is 6; then the footer.
  task automatic send_frame(input logic [15:0] hdr, cmd, len, input int n, keep,
                            input bit bad_crc, clean);
    logic [7:0]  head [6];
    logic [15:0] crc;
    logic [7:0]  b;
    head = '{hdr[15:8], hdr[7:0], cmd[15:8], cmd[7:0], len[15:8], len[7:0]};
    crc = CRC_INIT;
    for (int i = 0; i < keep; i++) begin
      send_byte(head[i]);
      crc = crc_add(crc, head[i]);
    end
    if (keep == 6) begin
      repeat (n) begin
        b = clean ? 8'($urandom_range(0, 254)) : 8'($urandom_range(0, 255));
        send_byte(b);
        crc = crc_add(crc, b);
      end
      if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
      send_byte(crc[15:8]);
      send_byte(crc[7:0]);
    end
    send_footer();
  endtask

  // Stop sending and let every expected verdict drain out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [15:0] v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_now = v;
    cfg_writes++;
  endtask

  function automatic plan_row_t frame_row(input logic [15:0] hdr, cmd, len, input int n, keep,
                                          input bit bad_crc, pinned, input status_t st,
                                          input int fb);
    plan_row_t r;
    logic [7:0] head [6];
    logic [7:0] foot [3];
    logic [7:0] seen [6];
    head = '{hdr[15:8], hdr[7:0], cmd[15:8], cmd[7:0], len[15:8], len[7:0]};
    foot = '{FOOTER_0, FOOTER_1, FOOTER_2};
    // In a short frame the footer bytes land in the header, command and length slots.
    for (int i = 0; i < 6; i++) begin
      if (i < keep) seen[i] = head[i];
      else if (i - keep < 3) seen[i] = foot[i - keep];
      else seen[i] = 8'h00;
    end
    r.kind = ROW_FRAME;
    r.hdr = hdr;
    r.cmd = cmd;
    r.len = len;
    r.n = n;
    r.keep = keep;
    r.bad_crc = bad_crc;
    r.pinned = pinned;
    r.want = '{st, {seen[2], seen[3]}, {seen[4], seen[5]}, FRAME_W'(fb)};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [15:0] v);
    plan_row_t r;
    r = frame_row('0, v, '0, 0, 0, 1'b0, 1'b0, ST_OK, 0);
    r.kind = ROW_CFG;
    return r;
  endfunction

  // One random stretch of traffic: whole frames (some broken), short frames, noise and stray footers.
  task automatic random_frame();
    int k, n;
    logic [15:0] hdr, cmd, len;
    k = $urandom_range(0, 99);
    if (k < 55) begin
      hdr = ($urandom_range(0, 19) == 0) ? 16'($urandom) : FRAME_HEADER;
      case ($urandom_range(0, 3))
        0, 1: cmd = cfg_now;
        2: cmd = ANY_COMMAND;
        default: cmd = 16'($urandom);
      endcase
      n = ($urandom_range(0, 49) == 0) ? $urandom_range(240, 270) : $urandom_range(0, 12);
      len = 16'(n);
      if ($urandom_range(0, 9) == 0)
        len = ($urandom_range(0, 1) == 0) ? 16'($urandom) : len + 16'd1;
      send_frame(hdr, cmd, len, n, 6, $urandom_range(0, 9) == 0, 1'b0);
    end else if (k < 70) begin
      // Frame cut short before its length word is complete.
      hdr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : FRAME_HEADER;
      send_frame(hdr, 16'($urandom), 16'($urandom), 0, $urandom_range(0, 5), 1'b0, 1'b0);
    end else if (k < 85) begin
      repeat ($urandom_range(1, 24)) send_byte(8'($urandom));
      if ($urandom_range(0, 1) == 0) send_footer();
    end else begin
      // Stray footer fragments.
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0: send_byte(FOOTER_0);
          1: send_byte(FOOTER_1);
          2: send_byte(FOOTER_2);
          default: send_byte(8'h00);
        endcase
      end
    end
  endtask

  initial begin
    // Directed table: typed verdicts where the outcome is obvious, the tracker elsewhere.
    plan.push_back(frame_row(FRAME_HEADER, 16'h0000, 16'd0, 0, 6, 1'b0, 1'b1, ST_OK, 11));
    plan.push_back(frame_row(FRAME_HEADER, ANY_COMMAND, 16'd4, 4, 6, 1'b0, 1'b1, ST_OK, 15));
    plan.push_back(frame_row(16'hFFFF, 16'h0000, 16'd0, 0, 6, 1'b0, 1'b1, ST_BAD_HEADER, 11));
    plan.push_back(frame_row(16'h0000, ANY_COMMAND, 16'd1, 1, 6, 1'b0, 1'b1, ST_BAD_HEADER,
                             12));
    plan.push_back(frame_row(FRAME_HEADER, 16'hFFFF, 16'd0, 0, 6, 1'b0, 1'b1, ST_BAD_CMD, 11));
    plan.push_back(frame_row(FRAME_HEADER, 16'h0000, 16'hFFFE, 0, 6, 1'b0, 1'b1, ST_BAD_LENGTH,
                             11));
    plan.push_back(frame_row(FRAME_HEADER, 16'h0000, 16'd2, 2, 6, 1'b1, 1'b1, ST_BAD_CRC, 13));
    // Short frames: the footer fills the header, command and length slots it reaches.
    plan.push_back(frame_row(FRAME_HEADER, 16'h0000, 16'd0, 0, 0, 1'b0, 1'b1, ST_BAD_HEADER, 3));
    plan.push_back(frame_row(FRAME_HEADER, 16'h0000, 16'd0, 0, 2, 1'b0, 1'b1, ST_BAD_CMD, 5));
    plan.push_back(frame_row(FRAME_HEADER, ANY_COMMAND, 16'h0300, 0, 5, 1'b0, 1'b1,
                             ST_BAD_LENGTH, 8));
    // Longest legal frame, then over-long frames with a saturated count.
    plan.push_back(frame_row(FRAME_HEADER, 16'h0000, 16'd245, 245, 6, 1'b0, 1'b1, ST_OK, 256));
    plan.push_back(frame_row(FRAME_HEADER, 16'h0000, 16'd246, 246, 6, 1'b0, 1'b1,
                             ST_BAD_LENGTH, 257));
    plan.push_back(frame_row(FRAME_HEADER, 16'h0000, 16'd300, 300, 6, 1'b0, 1'b1,
                             ST_BAD_LENGTH, 257));
    plan.push_back(cfg_row(16'hFFFF));
    plan.push_back(frame_row(FRAME_HEADER, 16'hFFFF, 16'd3, 3, 6, 1'b0, 1'b1, ST_OK, 14));
    plan.push_back(frame_row(FRAME_HEADER, ANY_COMMAND, 16'd0, 0, 6, 1'b0, 1'b1, ST_OK, 11));
    plan.push_back(frame_row(FRAME_HEADER, 16'h0000, 16'd0, 0, 6, 1'b0, 1'b1, ST_BAD_CMD, 11));
    plan.push_back(frame_row(FRAME_HEADER, 16'h5A5A, 16'd6, 6, 6, 1'b0, 1'b0, ST_OK, 0));
    plan.push_back(cfg_row(ANY_COMMAND));
    plan.push_back(frame_row(FRAME_HEADER, ANY_COMMAND, 16'd5, 4, 6, 1'b1, 1'b1,
                             ST_BAD_LENGTH, 15));
    plan.push_back(frame_row(16'h01AB, 16'h1234, 16'd0, 0, 6, 1'b1, 1'b1, ST_BAD_HEADER, 11));
    plan.push_back(frame_row(FRAME_HEADER, 16'h8001, 16'd9, 9, 6, 1'b1, 1'b0, ST_OK, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_cfg(plan[i].cmd);
      end else begin
        directed_q.push_back('{plan[i].pinned, plan[i].want});
        send_frame(plan[i].hdr, plan[i].cmd, plan[i].len, plan[i].n, plan[i].keep,
                   plan[i].bad_crc, 1'b1);
      end
    end

    // Random phases, each with its own command setting; phase three has no idling or back-pressure.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_cfg(16'hFFFF);
        2: write_cfg(16'h0000);
        4: write_cfg(ANY_COMMAND);
        default: write_cfg(16'($urandom));
      endcase
      quiet = (ph == 3);
      k_start: begin
        int start;
        start = sent_bytes;
        while (sent_bytes - start < PHASE_BYTES) random_frame();
      end
      // Close any partial frame so the next register write finds the block idle.
      send_footer();
    end
    quiet = 1'b0;

    wait_drained();
    repeat (6) @(posedge clk);
    $display("Sent %0d bytes, %0d command writes; %0d verdicts checked.",
             sent_bytes, cfg_writes, verdicts);
    $display("Verdicts: %0d ok, %0d bad header, %0d bad command, %0d bad length, %0d bad crc.",
             st_seen[ST_OK], st_seen[ST_BAD_HEADER], st_seen[ST_BAD_CMD],
             st_seen[ST_BAD_LENGTH], st_seen[ST_BAD_CRC]);
    if (verdict_q.size() != 0) begin
      errors++;
      $display("%0t: %0d verdicts never arrived, expected 0, actual %0d",
               $time, verdict_q.size(), verdict_q.size());
    end
    if (errors == 0) begin
      $display("serial_frame_checker_crc16 regression: pass");
    end else begin
      $display("serial_frame_checker_crc16 regression: fail");
    end
    $finish;
  end

endmodule
